// ===== rtl/dmac_pkg.sv =====
// Shared types and constants of the register-programmed DMA copier.
package dmac_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	// CPU register byte offsets
	localparam logic [7:0] OFF_SRC   = 8'd0;
	localparam logic [7:0] OFF_TGT   = 8'd4;
	localparam logic [7:0] OFF_SIZE  = 8'd8;
	localparam logic [7:0] OFF_START = 8'd12;

	localparam logic [31:0] ADDR_STEP = 32'd4;
	localparam logic [31:0] START_GO  = 32'd1;

	typedef enum logic [1:0] {
		OP_RD  = 2'd0,
		OP_WR  = 2'd1,
		OP_RET = 2'd2,
		OP_CLR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_ACK   = 2'd0,
		KIND_RDATA = 2'd1,
		KIND_RREQ  = 2'd2,
		KIND_WREQ  = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] addr;
		logic [31:0] data;
	} res_t;

	// All results caused by one input word, queued as one entry.
	typedef struct packed {
		res_t r0;
		res_t r1;
		logic two;
		logic irq;
	} entry_t;

endpackage

// ===== rtl/register_programmed_dma_copier.sv =====
// Top level of the single-channel register-programmed DMA copier.
//
//   channel  direction  handshake              words
//   in       to block   in_valid / in_stall    op, reg_offset, bus_data
//   out      from block out_valid / out_stall  kind, out_address, out_data,
//                                              interrupt_level, last
//
// An input word is taken every cycle while the result queue has room; it
// gives zero, one or two output words, and the output register sends one a
// cycle while out_stall does not hold it, so a run of words that give two
// results fills the queue. Results pass a queue slot, then the output register.
// Reset clears the CPU registers, the copy sequencer and the queue at once.
// in_stall rises only while the result queue is full.
module register_programmed_dma_copier #(
	parameter int unsigned QUEUE_DEPTH = dmac_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [7:0]  reg_offset,
	input  logic [31:0] bus_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [31:0] out_address,
	output logic [31:0] out_data,
	output logic        interrupt_level,
	output logic        last
);
	import dmac_pkg::*;

	logic   accept, push, pop, empty, full;
	entry_t wr_entry, head;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	dmac_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.op         (op),
		.reg_offset (reg_offset),
		.bus_data   (bus_data),
		.push       (push),
		.entry      (wr_entry)
	);

	dmac_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	dmac_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.empty           (empty),
		.pop             (pop),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.kind            (kind),
		.out_address     (out_address),
		.out_data        (out_data),
		.interrupt_level (interrupt_level),
		.last            (last)
	);

endmodule

// ===== rtl/dmac_front.sv =====
// Front end: register file, copy sequencer and result building for each input word.
module dmac_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [1:0]           op,
	input  logic [7:0]           reg_offset,
	input  logic [31:0]          bus_data,
	output logic                 push,
	output dmac_pkg::entry_t     entry
);
	import dmac_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_WAIT = 3'b010,
		PH_DONE = 3'b100
	} phase_t;

	logic [31:0] source_q, target_q, size_q, start_q;
	logic [31:0] rd_addr_q, wr_addr_q;
	logic [29:0] index_q;
	phase_t      phase_q;
	logic        irq_q;

	logic [31:0] src_n, tgt_n, size_n, start_n, rd_n, wr_n, rdval;
	logic [29:0] index_n;
	phase_t      phase_n;
	logic        irq_n, has_res, do_react;
	entry_t      ent;

	always_comb begin
		unique case (reg_offset[7:2])
			OFF_SRC[7:2]:   rdval = source_q;
			OFF_TGT[7:2]:   rdval = target_q;
			OFF_SIZE[7:2]:  rdval = size_q;
			OFF_START[7:2]: rdval = start_q;
			default:        rdval = '0;
		endcase
	end

	always_comb begin
		src_n    = source_q;
		tgt_n    = target_q;
		size_n   = size_q;
		start_n  = start_q;
		rd_n     = rd_addr_q;
		wr_n     = wr_addr_q;
		index_n  = index_q;
		phase_n  = phase_q;
		irq_n    = irq_q;
		has_res  = 1'b1;
		do_react = 1'b1;
		ent      = '0;
		ent.r0.kind = KIND_ACK;
		ent.r1.kind = KIND_ACK;
		unique case (op_t'(op))
			OP_RD: begin
				ent.r0.kind = KIND_RDATA;
				ent.r0.data = rdval;
			end
			OP_WR: begin
				if (start_q == '0) begin
					if (reg_offset == OFF_SRC) src_n = bus_data;
					if (reg_offset == OFF_TGT) tgt_n = bus_data;
					if (reg_offset == OFF_SIZE) size_n = bus_data;
				end
				if (reg_offset == OFF_START) start_n = bus_data;
			end
			OP_CLR: begin
				src_n   = '0;
				tgt_n   = '0;
				size_n  = '0;
				start_n = '0;
			end
			OP_RET: begin
				do_react = 1'b0;
				if (phase_q == PH_WAIT) begin
					ent.r0.kind = KIND_WREQ;
					ent.r0.addr = wr_addr_q;
					ent.r0.data = bus_data;
					wr_n    = wr_addr_q + ADDR_STEP;
					index_n = index_q + 30'd1;
					// compare against the live size so a shrink ends the run early
					if (index_n < size_q[31:2]) begin
						rd_n        = rd_addr_q + ADDR_STEP;
						ent.two     = 1'b1;
						ent.r1.kind = KIND_RREQ;
						ent.r1.addr = rd_n;
					end else if (start_q == START_GO) begin
						irq_n   = 1'b1;
						phase_n = PH_DONE;
					end else begin
						irq_n   = 1'b0;
						phase_n = PH_IDLE;
					end
				end else begin
					// drop a return that no read is waiting for
					has_res = 1'b0;
				end
			end
			default: has_res = 1'b0;
		endcase
		if (do_react) begin
			if (phase_q == PH_DONE && start_n != START_GO) begin
				irq_n   = 1'b0;
				phase_n = PH_IDLE;
			end
			if (phase_n == PH_IDLE && start_n == START_GO) begin
				index_n = '0;
				rd_n    = src_n;
				wr_n    = tgt_n;
				if (size_n[31:2] == '0) begin
					irq_n   = 1'b1;
					phase_n = PH_DONE;
				end else begin
					phase_n     = PH_WAIT;
					ent.two     = 1'b1;
					ent.r1.kind = KIND_RREQ;
					ent.r1.addr = src_n;
				end
			end
		end
		ent.irq = irq_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_q  <= '0;
			target_q  <= '0;
			size_q    <= '0;
			start_q   <= '0;
			rd_addr_q <= '0;
			wr_addr_q <= '0;
			index_q   <= '0;
			phase_q   <= PH_IDLE;
			irq_q     <= 1'b0;
		end else if (accept) begin
			source_q  <= src_n;
			target_q  <= tgt_n;
			size_q    <= size_n;
			start_q   <= start_n;
			rd_addr_q <= rd_n;
			wr_addr_q <= wr_n;
			index_q   <= index_n;
			phase_q   <= phase_n;
			irq_q     <= irq_n;
		end
	end

	assign push  = accept && has_res;
	assign entry = ent;

endmodule

// ===== rtl/dmac_queue.sv =====
// Short result queue between the front end and the output stage.
module dmac_queue #(
	parameter int unsigned DEPTH = dmac_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  dmac_pkg::entry_t wr_entry,
	input  logic             pop,
	output dmac_pkg::entry_t head,
	output logic             empty,
	output logic             full
);
	import dmac_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	entry_t          slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CW'(DEPTH));
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== rtl/dmac_back.sv =====
// Output stage: drains queue entries one result word per cycle into the output register while out_stall allows.
module dmac_back (
	input  logic             clk,
	input  logic             arst_n,
	input  dmac_pkg::entry_t head,
	input  logic             empty,
	output logic             pop,
	input  logic             out_stall,
	output logic             out_valid,
	output logic [1:0]       kind,
	output logic [31:0]      out_address,
	output logic [31:0]      out_data,
	output logic             interrupt_level,
	output logic             last
);
	import dmac_pkg::*;

	logic        valid_q, sel_q, free, load, last_n;
	res_t        res;
	kind_t       kind_q;
	logic [31:0] addr_q, data_q;
	logic        irq_q, last_q;

	assign free   = !valid_q || !out_stall;
	assign load   = free && !empty;
	assign res    = sel_q ? head.r1 : head.r0;
	assign last_n = sel_q || !head.two;
	assign pop    = load && last_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			if (free) valid_q <= !empty;
			if (load) sel_q <= !last_n;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= res.kind;
			addr_q <= res.addr;
			data_q <= res.data;
			irq_q  <= head.irq;
			last_q <= last_n;
		end
	end

	assign out_valid       = valid_q;
	assign kind            = kind_q;
	assign out_address     = addr_q;
	assign out_data        = data_q;
	assign interrupt_level = irq_q;
	assign last            = last_q;

endmodule

// ===== rtl/dmac_checker.sv =====
// Port-level checks of the DMA copier, bound to its top level.
module dmac_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  kind,
	input logic [31:0] out_address,
	input logic [31:0] out_data,
	input logic        interrupt_level,
	input logic        last
);
	import dmac_pkg::*;

	// hold a stalled output word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(out_address)
			&& $stable(out_data) && $stable(last) && $stable(interrupt_level))
		else $error("stalled output word changed");

	// a read request always closes the results of its input
	a_rreq_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_RREQ |-> last)
		else $error("read request not marked last");

	// the second word of a pair is a read request and follows at once
	a_pair_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid && kind == KIND_RREQ)
		else $error("second word of pair missing or not a read request");

	// both words of a pair carry the same interrupt level
	a_pair_irq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> interrupt_level == $past(interrupt_level))
		else $error("interrupt level differs within a pair");

endmodule

bind register_programmed_dma_copier dmac_checker u_dmac_checker (.*);
